>>> rtl/core/pdtb_pkg.sv
// ---------------------------------------------------------------------------
// pdtb_pkg
// Shared types and constants of the point dedup table.
// ---------------------------------------------------------------------------
package pdtb_pkg;

    localparam int CAPACITY_DEF = 4096;
    localparam int BUCKETS_DEF  = 1024;
    localparam int LON_W        = 29;
    localparam int LAT_W        = 28;
    localparam int IDX_W        = 12;
    localparam int BOX_W        = 32;

    localparam logic signed [BOX_W-1:0] BOX_POS_LIMIT = 32'sh7fffffff;
    localparam logic signed [BOX_W-1:0] BOX_NEG_LIMIT = -32'sh7fffffff;

    typedef struct packed {
        logic signed [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
    } point_t;

    typedef struct packed {
        logic [IDX_W-1:0]        point_index;
        logic                    is_new;
        logic                    full_res;
        logic signed [BOX_W-1:0] box_min_lon;
        logic signed [BOX_W-1:0] box_max_lon;
        logic signed [BOX_W-1:0] box_min_lat;
        logic signed [BOX_W-1:0] box_max_lat;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;   // clear one bucket head
        logic load;       // capture input, read head
        logic chase;      // read entry at current link
        logic compare;    // evaluate entry data
        logic append;     // write new point
        logic reject;     // full result
        logic hit;        // duplicate result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic link_zero;
        logic match;
        logic full;
    } status_t;

endpackage

>>> rtl/core/point_dedup_table_with_bounds_unit.sv
// ---------------------------------------------------------------------------
// point_dedup_table_with_bounds_unit
// Hashed point table with dedup lookup, append and running bounding box.
// ---------------------------------------------------------------------------
//  channel | ports             | payload
//  input   | s_valid s_ready   | s_data  (pdtb_pkg::point_t)
//  result  | m_valid m_ready   | m_data  (pdtb_pkg::result_t)
//
//  One item at a time; each chain entry walked takes one memory read and
//  one compare, for new, rejected and duplicate points alike. After reset
//  a sweep clears the bucket heads; no input is taken during it. A result
//  waits in its register under m_ready low and holds off the input; the
//  next item is taken as the result drains.
// ---------------------------------------------------------------------------
module point_dedup_table_with_bounds_unit #(
    parameter int CAPACITY = pdtb_pkg::CAPACITY_DEF,
    parameter int BUCKETS  = pdtb_pkg::BUCKETS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pdtb_pkg::point_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pdtb_pkg::result_t m_data
);

    pdtb_pkg::cmd_t    cmd;
    pdtb_pkg::status_t status;

    pdtb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .status(status)
    );

    pdtb_datapath #(.CAPACITY(CAPACITY), .BUCKETS(BUCKETS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_data(s_data), .cmd(cmd),
        .status(status), .m_data(m_data)
    );

    // a result never claims both new and full
    a_new_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.is_new && m_data.full_res))
        else $error("result both new and full");

    // a full result carries index zero
    a_full_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.full_res) |-> (m_data.point_index == '0))
        else $error("full result with nonzero index");

    // only one command of the result group at a time
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.hit, cmd.append, cmd.reject, cmd.load}))
        else $error("conflicting commands");

endmodule

>>> rtl/core/pdtb_ctrl.sv
// ---------------------------------------------------------------------------
// pdtb_ctrl
// Sequencer: head clear sweep, chain walk, append or report.
// ---------------------------------------------------------------------------
module pdtb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output pdtb_pkg::cmd_t    cmd,
    input  pdtb_pkg::status_t status
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_HEAD  = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_CMP   = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign m_valid = out_valid_reg;
    // accept when idle and result slot is free or draining
    assign s_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                // current link now registered (head_reg on the first visit, link_reg after)
                if (status.link_zero) state_next = ST_DONE;
                else begin
                    cmd.chase  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_CMP;
            ST_CMP: begin
                cmd.compare = 1'b1;
                if (status.match) begin
                    cmd.hit    = 1'b1;
                    state_next = ST_OUT;
                end else state_next = ST_HEAD;
            end
            ST_DONE: begin
                if (status.full) cmd.reject = 1'b1;
                else cmd.append = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/pdtb_datapath.sv
// ---------------------------------------------------------------------------
// pdtb_datapath
// Point, link and head memories, compare, bounding box and result register.
// ---------------------------------------------------------------------------
module pdtb_datapath #(
    parameter int CAPACITY = pdtb_pkg::CAPACITY_DEF,
    parameter int BUCKETS  = pdtb_pkg::BUCKETS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pdtb_pkg::point_t   s_data,
    input  pdtb_pkg::cmd_t     cmd,
    output pdtb_pkg::status_t  status,
    output pdtb_pkg::result_t  m_data
);

    localparam int EW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int BW = $clog2(BUCKETS);
    localparam int IW = pdtb_pkg::IDX_W;

    logic [pdtb_pkg::LON_W-1:0] mem_lon [CAPACITY];
    logic [pdtb_pkg::LAT_W-1:0] mem_lat [CAPACITY];
    logic [LW-1:0]              mem_next[CAPACITY];
    logic [LW-1:0]              mem_head[BUCKETS];

    pdtb_pkg::point_t   pt_reg;
    logic [BW-1:0]      bucket_reg;
    logic [BW:0]        clr_cnt_reg;
    logic [LW-1:0]      link_reg, head_reg;
    logic [LW-1:0]      rd_next_reg;
    logic [pdtb_pkg::LON_W-1:0] rd_lon_reg;
    logic [pdtb_pkg::LAT_W-1:0] rd_lat_reg;
    logic [LW-1:0]      total_reg, steps_reg;
    logic               head_cycle_reg;
    logic signed [pdtb_pkg::BOX_W-1:0] min_lon_reg, max_lon_reg, min_lat_reg, max_lat_reg;
    pdtb_pkg::result_t  res_reg;

    logic [BW-1:0]      bucket_in;
    logic [EW-1:0]      ent;
    logic signed [pdtb_pkg::BOX_W-1:0] lon32, lat32;
    logic               match;

    // bucket = lon bit pattern mod BUCKETS (the user must keep BUCKETS a power of two; not enforced here)
    assign bucket_in = s_data.lon[BW-1:0];

    logic [LW-1:0] link_now;
    assign link_now = head_cycle_reg ? head_reg : link_reg;
    assign ent      = EW'(link_now - LW'(1));
    assign lon32    = pdtb_pkg::BOX_W'(pt_reg.lon);
    assign lat32    = pdtb_pkg::BOX_W'(pt_reg.lat);
    assign match    = (rd_lon_reg == pt_reg.lon) && (rd_lat_reg == pt_reg.lat);

    assign status.clr_done  = (clr_cnt_reg == (BW+1)'(BUCKETS - 1));
    assign status.link_zero = (link_now == '0) || (steps_reg >= LW'(CAPACITY));
    assign status.match     = match;
    assign status.full      = (total_reg >= LW'(CAPACITY));
    assign m_data           = res_reg;

    // head memory: clear sweep, read on load, write on append
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) mem_head[clr_cnt_reg[BW-1:0]] <= '0;
        else if (cmd.append) mem_head[bucket_reg] <= total_reg + LW'(1);
        if (cmd.load) head_reg <= mem_head[bucket_in];
    end

    // point and link memories; a new entry links to the bucket's old head
    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            mem_lon[total_reg[EW-1:0]]  <= pt_reg.lon;
            mem_lat[total_reg[EW-1:0]]  <= pt_reg.lat;
            mem_next[total_reg[EW-1:0]] <= head_reg;
        end
        if (cmd.chase) begin
            rd_lon_reg  <= mem_lon[ent];
            rd_lat_reg  <= mem_lat[ent];
            rd_next_reg <= mem_next[ent];
        end
    end

    // walk control, clear counter, entry count and bounding box
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg    <= '0;
            total_reg      <= '0;
            head_cycle_reg <= 1'b0;
            min_lon_reg    <= pdtb_pkg::BOX_POS_LIMIT;
            max_lon_reg    <= pdtb_pkg::BOX_NEG_LIMIT;
            min_lat_reg    <= pdtb_pkg::BOX_POS_LIMIT;
            max_lat_reg    <= pdtb_pkg::BOX_NEG_LIMIT;
        end else begin
            if (cmd.clr_step) clr_cnt_reg <= clr_cnt_reg + (BW+1)'(1);
            if (cmd.load) begin
                pt_reg         <= s_data;
                bucket_reg     <= bucket_in;
                steps_reg      <= '0;
                head_cycle_reg <= 1'b1;
            end
            if (cmd.chase) begin
                link_reg       <= link_now;
                head_cycle_reg <= 1'b0;
            end
            if (cmd.compare) begin
                link_reg  <= rd_next_reg;
                steps_reg <= steps_reg + LW'(1);
            end
            if (cmd.append) begin
                // original head stays in head_reg until the next load
                head_cycle_reg <= 1'b0;
                total_reg <= total_reg + LW'(1);
                if (lon32 < min_lon_reg) min_lon_reg <= lon32;
                if (lon32 > max_lon_reg) max_lon_reg <= lon32;
                if (lat32 < min_lat_reg) min_lat_reg <= lat32;
                if (lat32 > max_lat_reg) max_lat_reg <= lat32;
            end
        end
    end

    // result register, box taken from post-update values
    logic signed [pdtb_pkg::BOX_W-1:0] nmin_lon, nmax_lon, nmin_lat, nmax_lat;
    always_comb begin
        nmin_lon = (cmd.append && lon32 < min_lon_reg) ? lon32 : min_lon_reg;
        nmax_lon = (cmd.append && lon32 > max_lon_reg) ? lon32 : max_lon_reg;
        nmin_lat = (cmd.append && lat32 < min_lat_reg) ? lat32 : min_lat_reg;
        nmax_lat = (cmd.append && lat32 > max_lat_reg) ? lat32 : max_lat_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.hit || cmd.append || cmd.reject) begin
            res_reg.point_index <= cmd.hit ? IW'(EW'(link_reg - LW'(1))) :
                                   cmd.append ? IW'(total_reg) : '0;
            res_reg.is_new      <= cmd.append;
            res_reg.full_res    <= cmd.reject;
            res_reg.box_min_lon <= nmin_lon;
            res_reg.box_max_lon <= nmax_lon;
            res_reg.box_min_lat <= nmin_lat;
            res_reg.box_max_lat <= nmax_lat;
        end
    end

endmodule

>>> test/point_dedup_table_with_bounds_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// point_dedup_table_with_bounds_unit_tb
// Drives points into the dedup table and checks every result against a
// behavioral copy of the hashed table and bounding box. The run covers
// directed corner points, random traffic under several idle/stall mixes,
// a long receiver hold-off, and a repeat-heavy phase.
// ---------------------------------------------------------------------------
module point_dedup_table_with_bounds_unit_tb;

    localparam int TBL_DEPTH  = pdtb_pkg::CAPACITY_DEF;
    localparam int HEAD_DEPTH = pdtb_pkg::BUCKETS_DEF;
    localparam int STALL_MAX  = 5000;
    localparam int LON_W      = pdtb_pkg::LON_W;
    localparam int LAT_W      = pdtb_pkg::LAT_W;
    localparam int BOX_W      = pdtb_pkg::BOX_W;
    localparam int IDX_W      = pdtb_pkg::IDX_W;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    pdtb_pkg::point_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    pdtb_pkg::result_t m_data;

    point_dedup_table_with_bounds_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Shadow copy of the table
    logic signed [LON_W-1:0] tbl_lon [TBL_DEPTH];
    logic signed [LAT_W-1:0] tbl_lat [TBL_DEPTH];
    int unsigned             tbl_link[TBL_DEPTH];
    int unsigned             tbl_head[HEAD_DEPTH];
    int unsigned             tbl_total;
    logic signed [BOX_W-1:0] bx_min_lon, bx_max_lon, bx_min_lat, bx_max_lat;

    pdtb_pkg::result_t pending_results[$];
    pdtb_pkg::point_t  seen_points[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_cycles = 0;

    initial forever #4 aclk = ~aclk;

    // Lookup, append and box update for one point
    function automatic pdtb_pkg::result_t lookup_point(pdtb_pkg::point_t p);
        pdtb_pkg::result_t r;
        int unsigned bkt, lnk, steps, e;
        logic        found;
        r = '0;
        bkt = int'(p.lon[9:0]) % HEAD_DEPTH;
        lnk = tbl_head[bkt];
        steps = 0;
        found = 1'b0;
        while (lnk != 0 && steps < TBL_DEPTH && !found) begin
            e = lnk - 1;
            if (tbl_lon[e] == p.lon && tbl_lat[e] == p.lat) begin
                found = 1'b1;
                r.point_index = e[IDX_W-1:0];
            end else begin
                lnk = tbl_link[e];
                steps++;
            end
        end
        if (!found) begin
            if (tbl_total >= TBL_DEPTH) begin
                r.full_res = 1'b1;
            end else begin
                e = tbl_total;
                tbl_lon[e] = p.lon;
                tbl_lat[e] = p.lat;
                tbl_link[e] = tbl_head[bkt];
                tbl_head[bkt] = e + 1;
                tbl_total++;
                r.point_index = e[IDX_W-1:0];
                r.is_new = 1'b1;
                if (BOX_W'(p.lon) < bx_min_lon) bx_min_lon = BOX_W'(p.lon);
                if (BOX_W'(p.lon) > bx_max_lon) bx_max_lon = BOX_W'(p.lon);
                if (BOX_W'(p.lat) < bx_min_lat) bx_min_lat = BOX_W'(p.lat);
                if (BOX_W'(p.lat) > bx_max_lat) bx_max_lat = BOX_W'(p.lat);
            end
        end
        r.box_min_lon = bx_min_lon;
        r.box_max_lon = bx_max_lon;
        r.box_min_lat = bx_min_lat;
        r.box_max_lat = bx_max_lat;
        return r;
    endfunction

    // Send one transaction, with random idle cycles ahead of it
    task automatic send_point(pdtb_pkg::point_t p);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(lookup_point(p));
        seen_points.push_back(p);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic pdtb_pkg::point_t make_point(int lon, int lat);
        pdtb_pkg::point_t p;
        p.lon = lon[LON_W-1:0];
        p.lat = lat[LAT_W-1:0];
        return p;
    endfunction

    // Random point: a repeat, a bucket neighbor of an old point, or fresh
    function automatic pdtb_pkg::point_t pick_point(int dup_pct);
        pdtb_pkg::point_t p;
        int     sel;
        sel = $urandom_range(99);
        p.lon = LON_W'($urandom);
        p.lat = LAT_W'($urandom);
        if ($urandom_range(1)) begin
            p.lon = LON_W'($urandom_range(360000000)) - LON_W'(180000000);
            p.lat = LAT_W'($urandom_range(180000000)) - LAT_W'(90000000);
        end
        if (seen_points.size() != 0) begin
            if (sel < dup_pct) begin
                p = seen_points[$urandom_range(seen_points.size() - 1)];
            end else if (sel < dup_pct + 15) begin
                p = seen_points[$urandom_range(seen_points.size() - 1)];
                if ($urandom_range(1))
                    p.lon = p.lon + LON_W'($urandom_range(1, 8) * HEAD_DEPTH);
                else
                    p.lat = p.lat + LAT_W'($urandom_range(1, 1000));
            end
        end
        return p;
    endfunction

    // Result checking and receiver back-pressure
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $realtime, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        pdtb_pkg::result_t want;
        if (m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $realtime, m_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("point_index", 32'(want.point_index), 32'(m_data.point_index));
                check_field("is_new", 32'(want.is_new), 32'(m_data.is_new));
                check_field("full_res", 32'(want.full_res), 32'(m_data.full_res));
                check_field("box_min_lon", want.box_min_lon, m_data.box_min_lon);
                check_field("box_max_lon", want.box_max_lon, m_data.box_max_lon);
                check_field("box_min_lat", want.box_min_lat, m_data.box_min_lat);
                check_field("box_max_lat", want.box_max_lat, m_data.box_max_lat);
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles without any transaction
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("point_dedup_table_with_bounds_unit test failed");
            $finish;
        end
    end

    // Corner values, chains within one bucket, repeats
    task automatic test_directed();
        send_point(make_point(0, 0));
        send_point(make_point(0, 0));
        send_point(make_point(180000000, 90000000));
        send_point(make_point(-180000000, -90000000));
        send_point(make_point(-(1 << 28), -(1 << 27)));
        send_point(make_point((1 << 28) - 1, (1 << 27) - 1));
        send_point(make_point(1024, 0));
        send_point(make_point(2048, 0));
        send_point(make_point(0, 1));
        send_point(make_point(1024, 0));
        send_point(make_point(0, 0));
        send_point(make_point(-1, -1));
        send_point(make_point(-1, 5));
        send_point(make_point(-1, -1));
        send_point(make_point(-180000000, -90000000));
        send_point(make_point((1 << 28) - 1, (1 << 27) - 1));
        send_point(make_point(123456789, -7654321));
        wait_drained();
    endtask

    task automatic test_random(int count, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        repeat (count) send_point(pick_point(40));
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // Receiver holds off while items keep coming, so the input stalls
    task automatic test_backpressure();
        hold_cycles = 400;
        repeat (20) send_point(pick_point(30));
        wait_drained();
    endtask

    // Mostly repeats of stored points, with idle and stall mixed in
    task automatic test_repeats();
        send_idle_pct = 35;
        recv_stall_pct = 35;
        repeat (500) send_point(pick_point(80));
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        tbl_total = 0;
        bx_min_lon = pdtb_pkg::BOX_POS_LIMIT;
        bx_max_lon = pdtb_pkg::BOX_NEG_LIMIT;
        bx_min_lat = pdtb_pkg::BOX_POS_LIMIT;
        bx_max_lat = pdtb_pkg::BOX_NEG_LIMIT;
        foreach (tbl_head[i]) tbl_head[i] = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(350, 0, 0);
        test_random(350, 50, 0);
        test_backpressure();
        test_random(350, 0, 50);
        test_random(350, 35, 35);
        test_repeats();
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("point_dedup_table_with_bounds_unit test passed");
        else
            $display("point_dedup_table_with_bounds_unit test failed");
        $finish;
    end
endmodule
